### hdl/adrc_pkg.sv
// Shared constants and types for the ADRC observer/controller block.
`default_nettype none

package adrc_pkg;

  localparam int DATA_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 16;

  // time step is unsigned Q0.32
  localparam int TS_FRAC = 32;
  localparam logic [TS_FRAC-1:0] TS_RESET = 32'd4294967;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PLANT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_BW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBS_BW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MAX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd7;

  // launch of one operation on the shared multiplier or divider
  typedef struct packed {
    logic start;
    logic neg;       // sign of the result
    logic ts_shift;  // scale by the Q0.32 time step format instead of the data format
  } op_ctl_t;

endpackage

`default_nettype wire

### hdl/adrc_mul.sv
// Bit-serial shift-add multiplier with fixed-point scaling and saturation.
`default_nettype none

module adrc_mul #(
  parameter int DATA_WIDTH = adrc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = adrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire adrc_pkg::op_ctl_t            ctl,
  input  wire logic [DATA_WIDTH-1:0]        a_mag,
  input  wire logic [DATA_WIDTH-1:0]        b_mag,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      res
);
  import adrc_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [DATA_WIDTH-1:0]     a_reg;
  logic [2*DATA_WIDTH-1:0]   prod;
  logic                      neg;
  logic                      ts;
  logic [DATA_WIDTH:0]       sum;
  logic [2*DATA_WIDTH-1:0]   sh;
  logic                      ovf;
  logic [DATA_WIDTH-2:0]     m;

  // upper half accumulates, multiplier bits leave from the bottom
  assign sum = {1'b0, prod[2*DATA_WIDTH-1:DATA_WIDTH]}
             + (prod[0] ? {1'b0, a_reg} : {(DATA_WIDTH+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DATA_WIDTH-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_reg <= a_mag;
      prod  <= {{DATA_WIDTH{1'b0}}, b_mag};
      neg   <= ctl.neg;
      ts    <= ctl.ts_shift;
    end else if (busy) begin
      prod <= {sum, prod[DATA_WIDTH-1:1]};
    end
  end

  always_comb begin
    sh  = ts ? (prod >> TS_FRAC) : (prod >> FRAC_BITS);
    ovf = |sh[2*DATA_WIDTH-1:DATA_WIDTH-1];
    m   = sh[DATA_WIDTH-2:0];
    if (ovf)
      res = neg ? MINV : MAXV;
    else
      res = neg ? -{1'b0, m} : {1'b0, m};
  end

endmodule

`default_nettype wire

### hdl/adrc_div.sv
// Restoring divider, one quotient bit a cycle, fixed-point scaling and saturation.
`default_nettype none

module adrc_div #(
  parameter int DATA_WIDTH = adrc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = adrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire adrc_pkg::op_ctl_t            ctl,
  input  wire logic [DATA_WIDTH-1:0]        num_mag,
  input  wire logic [DATA_WIDTH-1:0]        divisor,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      res
);
  import adrc_pkg::*;

  localparam int DVW = DATA_WIDTH + TS_FRAC;
  localparam int CW  = $clog2(DVW);
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          last;
  logic [DVW-1:0]         dvd;
  logic [DATA_WIDTH-1:0]  rem;
  logic [DATA_WIDTH-1:0]  q;
  logic [DATA_WIDTH-1:0]  dsr;
  logic                   ovf;
  logic                   neg;
  logic [DATA_WIDTH:0]    r2;
  logic [DATA_WIDTH:0]    diff;
  logic                   ge;
  logic                   ov;

  // dividend is left aligned; the scale only sets how many bits are brought down
  assign r2   = {rem, dvd[DVW-1]};
  assign diff = r2 - {1'b0, dsr};
  assign ge   = !diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      last <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        last <= ctl.ts_shift ? CW'(DVW-1) : CW'(DATA_WIDTH+FRAC_BITS-1);
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= {num_mag, {TS_FRAC{1'b0}}};
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      dsr <= divisor;
      neg <= ctl.neg;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= ge ? diff[DATA_WIDTH-1:0] : r2[DATA_WIDTH-1:0];
      q   <= {q[DATA_WIDTH-2:0], ge};
      ovf <= ovf | q[DATA_WIDTH-1];
    end
  end

  always_comb begin
    ov = ovf | q[DATA_WIDTH-1];
    if (ov)
      res = neg ? MINV : MAXV;
    else
      res = neg ? -{1'b0, q[DATA_WIDTH-2:0]} : {1'b0, q[DATA_WIDTH-2:0]};
  end

endmodule

`default_nettype wire

### hdl/adrc_observer_controller.sv
// ADRC top level: registers, sequencer, shared adder and clamp, multiplier and divider.
`default_nettype none

// Linear ADRC for one joint: third-order extended state observer (Euler) plus PD drive
// with disturbance cancellation, divided by the plant gain and saturated. All values are
// signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits; the time step is
// unsigned Q0.32. A start word (cmd = 1) returns a drive of zero. A control step word
// runs 34 operations in sequence through one saturating adder, one clamp unit, a
// bit-serial multiplier (used 12 times) and a restoring divider (one bit a cycle, used
// twice: for the velocity limit and for the drive); a zero time step or zero plant gain
// skips the matching division. item_ready is high only between words; a finished result
// sits in the output register and the next word is taken while it waits.
module adrc_observer_controller #(
  parameter int DATA_WIDTH = adrc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = adrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [adrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [DATA_WIDTH-1:0]             cfg_data,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic                              cmd,
  input  wire logic signed [DATA_WIDTH-1:0]      measured_pos,
  input  wire logic signed [DATA_WIDTH-1:0]      ref_pos,
  input  wire logic signed [DATA_WIDTH-1:0]      ref_vel,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic signed [DATA_WIDTH-1:0]           drive
);
  import adrc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-2:0] ONE_Q = {{(DW-2){1'b0}}, 1'b1} << FRAC_BITS;

  // sequencer codes are consecutive: most steps advance to state + 1
  localparam int SW = 6;
  localparam logic [SW-1:0] S_IDLE = 6'd0;
  localparam logic [SW-1:0] S_LIM  = 6'd1;
  localparam logic [SW-1:0] S_KD   = 6'd2;
  localparam logic [SW-1:0] S_B1A  = 6'd3;
  localparam logic [SW-1:0] S_B1B  = 6'd4;
  localparam logic [SW-1:0] S_ERR  = 6'd5;
  localparam logic [SW-1:0] S_KP   = 6'd6;
  localparam logic [SW-1:0] S_WO2  = 6'd7;
  localparam logic [SW-1:0] S_B2A  = 6'd8;
  localparam logic [SW-1:0] S_B2B  = 6'd9;
  localparam logic [SW-1:0] S_B3   = 6'd10;
  localparam logic [SW-1:0] S_T1   = 6'd11;
  localparam logic [SW-1:0] S_T2   = 6'd12;
  localparam logic [SW-1:0] S_T3   = 6'd13;
  localparam logic [SW-1:0] S_P    = 6'd14;
  localparam logic [SW-1:0] S_CP   = 6'd15;
  localparam logic [SW-1:0] S_T4   = 6'd16;
  localparam logic [SW-1:0] S_T5   = 6'd17;
  localparam logic [SW-1:0] S_U1   = 6'd18;
  localparam logic [SW-1:0] S_T6   = 6'd19;
  localparam logic [SW-1:0] S_T7   = 6'd20;
  localparam logic [SW-1:0] S_V    = 6'd21;
  localparam logic [SW-1:0] S_CV   = 6'd22;
  localparam logic [SW-1:0] S_T8   = 6'd23;
  localparam logic [SW-1:0] S_T9   = 6'd24;
  localparam logic [SW-1:0] S_D    = 6'd25;
  localparam logic [SW-1:0] S_CD   = 6'd26;
  localparam logic [SW-1:0] S_T10  = 6'd27;
  localparam logic [SW-1:0] S_T11  = 6'd28;
  localparam logic [SW-1:0] S_U2   = 6'd29;
  localparam logic [SW-1:0] S_U3   = 6'd30;
  localparam logic [SW-1:0] S_T12  = 6'd31;
  localparam logic [SW-1:0] S_N    = 6'd32;
  localparam logic [SW-1:0] S_Q    = 6'd33;
  localparam logic [SW-1:0] S_CQ   = 6'd34;
  localparam logic [SW-1:0] S_FIN  = 6'd35;

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_ADD   = 3'd1;
  localparam logic [2:0] K_MUL   = 3'd2;
  localparam logic [2:0] K_DIV   = 3'd3;
  localparam logic [2:0] K_CLAMP = 3'd4;

  // configuration
  logic [DW-2:0]         plant_gain;
  logic [DW-2:0]         ctrl_bandwidth;
  logic [DW-2:0]         obs_bandwidth;
  logic [TS_FRAC-1:0]    time_step;
  logic signed [DW-1:0]  pos_low;
  logic signed [DW-1:0]  pos_high;
  logic [DW-2:0]         vel_max;
  logic [DW-2:0]         drive_max;

  // observer state
  logic signed [DW-1:0]  est_pos;
  logic signed [DW-1:0]  est_vel;
  logic signed [DW-1:0]  est_dist;
  logic signed [DW-1:0]  last_drive;

  // captured inputs and working registers
  logic signed [DW-1:0]  y;
  logic signed [DW-1:0]  xr;
  logic signed [DW-1:0]  vr;
  logic signed [DW-1:0]  kp;
  logic signed [DW-1:0]  kd;
  logic signed [DW-1:0]  b1;
  logic signed [DW-1:0]  wo2;
  logic signed [DW-1:0]  b2;
  logic signed [DW-1:0]  b3;
  logic signed [DW-1:0]  e;
  logic signed [DW-1:0]  t;
  logic signed [DW-1:0]  u;
  logic signed [DW-1:0]  lim;

  logic [SW-1:0]         state;
  logic [SW-1:0]         state_next;
  logic                  launched;

  // operand views
  logic signed [DW-1:0]  wc;
  logic signed [DW-1:0]  wo;
  logic signed [DW-1:0]  bg;
  logic signed [DW-1:0]  vm;
  logic signed [DW-1:0]  dm;
  logic signed [DW-1:0]  neg_vm;
  logic signed [DW-1:0]  neg_dm;
  logic signed [DW-1:0]  neg_lim;
  logic [DW-1:0]         h_ext;

  logic [2:0]            kind;
  logic signed [DW-1:0]  add_a;
  logic signed [DW-1:0]  add_b;
  logic                  add_sub;
  logic signed [DW:0]    add_s;
  logic signed [DW-1:0]  add_res;
  logic signed [DW-1:0]  mul_a;
  logic signed [DW-1:0]  mul_b;
  logic                  mul_h;
  logic signed [DW-1:0]  cl_v;
  logic signed [DW-1:0]  cl_lo;
  logic signed [DW-1:0]  cl_hi;
  logic signed [DW-1:0]  cl_res;
  logic signed [DW-1:0]  op_res;
  logic                  div_skip;
  logic signed [DW-1:0]  skip_res;
  logic                  adv;
  logic                  fin_load;

  op_ctl_t               mul_ctl;
  op_ctl_t               div_ctl;
  logic [DW-1:0]         mul_a_mag;
  logic [DW-1:0]         mul_b_mag;
  logic                  mul_done;
  logic signed [DW-1:0]  mul_res;
  logic [DW-1:0]         div_num;
  logic [DW-1:0]         div_dsr;
  logic                  div_done;
  logic signed [DW-1:0]  div_res;

  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  assign wc      = {1'b0, ctrl_bandwidth};
  assign wo      = {1'b0, obs_bandwidth};
  assign bg      = {1'b0, plant_gain};
  assign vm      = {1'b0, vel_max};
  assign dm      = {1'b0, drive_max};
  assign neg_vm  = -vm;
  assign neg_dm  = -dm;
  assign neg_lim = -lim;
  assign h_ext   = DW'(time_step);

  assign item_ready = (state == S_IDLE);

  // operation and operand selection per step
  always_comb begin
    kind    = K_NONE;
    add_a   = t;
    add_b   = u;
    add_sub = 1'b0;
    mul_a   = t;
    mul_b   = t;
    mul_h   = 1'b0;
    cl_v    = t;
    cl_lo   = neg_dm;
    cl_hi   = dm;
    unique case (state)
      S_LIM:   kind = K_DIV;
      S_KD:    begin kind = K_ADD; add_a = wc; add_b = wc; end
      S_B1A:   begin kind = K_ADD; add_a = wo; add_b = wo; end
      S_B1B:   begin kind = K_ADD; add_a = b1; add_b = wo; end
      S_ERR:   begin kind = K_ADD; add_a = y; add_b = est_pos; add_sub = 1'b1; end
      S_KP:    begin kind = K_MUL; mul_a = wc; mul_b = wc; end
      S_WO2:   begin kind = K_MUL; mul_a = wo; mul_b = wo; end
      S_B2A:   begin kind = K_ADD; add_a = wo2; add_b = wo2; end
      S_B2B:   begin kind = K_ADD; add_a = b2; add_b = wo2; end
      S_B3:    begin kind = K_MUL; mul_a = wo2; mul_b = wo; end
      S_T1:    begin kind = K_MUL; mul_a = b1; mul_b = e; end
      S_T2:    begin kind = K_ADD; add_a = est_vel; add_b = t; end
      S_T3:    begin kind = K_MUL; mul_h = 1'b1; end
      S_P:     begin kind = K_ADD; add_a = est_pos; add_b = t; end
      S_CP:    begin kind = K_CLAMP; cl_v = est_pos; cl_lo = pos_low; cl_hi = pos_high; end
      S_T4:    begin kind = K_MUL; mul_a = bg; mul_b = last_drive; end
      S_T5:    begin kind = K_ADD; add_a = est_dist; add_b = t; end
      S_U1:    begin kind = K_MUL; mul_a = b2; mul_b = e; end
      S_T6:    begin kind = K_ADD; add_a = t; add_b = u; end
      S_T7:    begin kind = K_MUL; mul_h = 1'b1; end
      S_V:     begin kind = K_ADD; add_a = est_vel; add_b = t; end
      S_CV:    begin kind = K_CLAMP; cl_v = est_vel; cl_lo = neg_vm; cl_hi = vm; end
      S_T8:    begin kind = K_MUL; mul_a = b3; mul_b = e; end
      S_T9:    begin kind = K_MUL; mul_h = 1'b1; end
      S_D:     begin kind = K_ADD; add_a = est_dist; add_b = t; end
      S_CD:    begin kind = K_CLAMP; cl_v = est_dist; cl_lo = neg_lim; cl_hi = lim; end
      S_T10:   begin kind = K_ADD; add_a = xr; add_b = y; add_sub = 1'b1; end
      S_T11:   begin kind = K_MUL; mul_a = kp; mul_b = t; end
      S_U2:    begin kind = K_ADD; add_a = vr; add_b = est_vel; add_sub = 1'b1; end
      S_U3:    begin kind = K_MUL; mul_a = kd; mul_b = u; end
      S_T12:   begin kind = K_ADD; add_a = t; add_b = u; end
      S_N:     begin kind = K_ADD; add_a = t; add_b = est_dist; add_sub = 1'b1; end
      S_Q:     kind = K_DIV;
      S_CQ:    begin kind = K_CLAMP; cl_v = t; cl_lo = neg_dm; cl_hi = dm; end
      default: kind = K_NONE;
    endcase
  end

  // shared saturating adder
  always_comb begin
    add_s = add_sub ? ({add_a[DW-1], add_a} - {add_b[DW-1], add_b})
                    : ({add_a[DW-1], add_a} + {add_b[DW-1], add_b});
    if (add_s[DW] != add_s[DW-1])
      add_res = add_s[DW] ? MINV : MAXV;
    else
      add_res = add_s[DW-1:0];
  end

  // shared clamp; a value below the low limit wins when the limits cross
  always_comb begin
    if (cl_v < cl_lo)
      cl_res = cl_lo;
    else if (cl_v > cl_hi)
      cl_res = cl_hi;
    else
      cl_res = cl_v;
  end

  // multiplier launch; h * x steps take the Q0.32 time step as first operand
  always_comb begin
    mul_a_mag        = mul_h ? h_ext : mag_of(mul_a);
    mul_b_mag        = mag_of(mul_b);
    mul_ctl.start    = (kind == K_MUL) && !launched;
    mul_ctl.neg      = mul_h ? mul_b[DW-1] : (mul_a[DW-1] ^ mul_b[DW-1]);
    mul_ctl.ts_shift = mul_h;
  end

  // divider launch: velocity limit over time step, or drive numerator over plant gain
  always_comb begin
    if (state == S_LIM) begin
      div_skip         = (time_step == '0);
      skip_res         = MAXV;
      div_num          = vm;
      div_dsr          = h_ext;
      div_ctl.neg      = 1'b0;
      div_ctl.ts_shift = 1'b1;
    end else begin
      div_skip         = (plant_gain == '0);
      skip_res         = t[DW-1] ? MINV : ((t == '0) ? '0 : MAXV);
      div_num          = mag_of(t);
      div_dsr          = bg;
      div_ctl.neg      = t[DW-1];
      div_ctl.ts_shift = 1'b0;
    end
    div_ctl.start = (kind == K_DIV) && !launched && !div_skip;
  end

  always_comb begin
    case (kind)
      K_ADD:   begin op_res = add_res; adv = 1'b1; end
      K_CLAMP: begin op_res = cl_res;  adv = 1'b1; end
      K_MUL:   begin op_res = mul_res; adv = mul_done; end
      K_DIV:   begin op_res = div_skip ? skip_res : div_res; adv = div_skip || div_done; end
      default: begin op_res = add_res; adv = 1'b0; end
    endcase
  end

  assign fin_load = (state == S_FIN) && (!result_valid || result_ready);

  always_comb begin
    state_next = state;
    if (state == S_IDLE) begin
      if (item_valid)
        state_next = cmd ? S_FIN : S_LIM;
    end else if (state == S_FIN) begin
      if (fin_load)
        state_next = S_IDLE;
    end else if (adv) begin
      state_next = state + SW'(1);
    end
  end

  // control, configuration and observer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      launched       <= 1'b0;
      result_valid   <= 1'b0;
      plant_gain     <= ONE_Q;
      ctrl_bandwidth <= ONE_Q;
      obs_bandwidth  <= ONE_Q;
      time_step      <= TS_RESET;
      pos_low        <= MINV;
      pos_high       <= MAXV;
      vel_max        <= '1;
      drive_max      <= '1;
      est_pos        <= '0;
      est_vel        <= '0;
      est_dist       <= '0;
      last_drive     <= '0;
    end else begin
      state <= state_next;

      if (adv)
        launched <= 1'b0;
      else if (mul_ctl.start || div_ctl.start)
        launched <= 1'b1;

      if (fin_load)
        result_valid <= 1'b1;
      else if (result_ready)
        result_valid <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          REG_PLANT_GAIN: plant_gain     <= cfg_data[DW-2:0];
          REG_CTRL_BW:    ctrl_bandwidth <= cfg_data[DW-2:0];
          REG_OBS_BW:     obs_bandwidth  <= cfg_data[DW-2:0];
          REG_TIME_STEP:  time_step      <= cfg_data[TS_FRAC-1:0];
          REG_POS_LOW:    pos_low        <= cfg_data;
          REG_POS_HIGH:   pos_high       <= cfg_data;
          REG_VEL_MAX:    vel_max        <= cfg_data[DW-2:0];
          REG_DRIVE_MAX:  drive_max      <= cfg_data[DW-2:0];
          default:        ;
        endcase
      end

      if (item_ready && item_valid && cmd) begin
        est_pos    <= measured_pos;
        est_vel    <= '0;
        est_dist   <= '0;
        last_drive <= '0;
      end else if (adv) begin
        unique case (state) inside
          S_P, S_CP: est_pos    <= op_res;
          S_V, S_CV: est_vel    <= op_res;
          S_D, S_CD: est_dist   <= op_res;
          S_CQ:      last_drive <= op_res;
          default:   ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      y  <= measured_pos;
      xr <= ref_pos;
      vr <= ref_vel;
    end
    if (adv) begin
      case (state) inside
        S_LIM:                                         lim <= op_res;
        S_KD:                                          kd  <= op_res;
        S_B1A, S_B1B:                                  b1  <= op_res;
        S_ERR:                                         e   <= op_res;
        S_KP:                                          kp  <= op_res;
        S_WO2:                                         wo2 <= op_res;
        S_B2A, S_B2B:                                  b2  <= op_res;
        S_B3:                                          b3  <= op_res;
        S_U1, S_U2, S_U3:                              u   <= op_res;
        S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7:      t   <= op_res;
        S_T8, S_T9, S_T10, S_T11, S_T12, S_N, S_Q:     t   <= op_res;
        default:                                       ;
      endcase
    end
    if (fin_load)
      drive <= last_drive;
  end

  adrc_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mul_ctl),
    .a_mag (mul_a_mag),
    .b_mag (mul_b_mag),
    .done  (mul_done),
    .res   (mul_res)
  );

  adrc_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .num_mag (div_num),
    .divisor (div_dsr),
    .done    (div_done),
    .res     (div_res)
  );

endmodule

`default_nettype wire
